[rtl/core/ps2sc_pkg.sv]
// Shared types, key codes and scancode tables for the PS/2 set 1 key decoder.
package ps2sc_pkg;

	localparam int ScanW  = 8;
	localparam int CodeW  = 7;
	localparam int KeyW   = 8;
	localparam int ModW   = 9;
	localparam int LedW   = 3;

	localparam logic [ScanW-1:0] SC_PREFIX = 8'hE0;

	// Scancodes of modifier and lock keys
	localparam logic [CodeW-1:0] SC_LSHIFT = 7'h2A;
	localparam logic [CodeW-1:0] SC_RSHIFT = 7'h36;
	localparam logic [CodeW-1:0] SC_CTRL   = 7'h1D;
	localparam logic [CodeW-1:0] SC_ALT    = 7'h38;
	localparam logic [CodeW-1:0] SC_CAPS   = 7'h3A;
	localparam logic [CodeW-1:0] SC_NUM    = 7'h45;
	localparam logic [CodeW-1:0] SC_SCROLL = 7'h46;

	// Modifier word bit positions
	localparam int M_LSHIFT = 0;
	localparam int M_RSHIFT = 1;
	localparam int M_LCTRL  = 2;
	localparam int M_RCTRL  = 3;
	localparam int M_LALT   = 4;
	localparam int M_RALT   = 5;
	localparam int M_CAPS   = 6;
	localparam int M_NUM    = 7;
	localparam int M_SCROLL = 8;

	// Special key codes
	localparam logic [KeyW-1:0] K_NONE  = 8'h00;
	localparam logic [KeyW-1:0] K_ESC   = 8'h80;
	localparam logic [KeyW-1:0] K_BS    = 8'h81;
	localparam logic [KeyW-1:0] K_TAB   = 8'h82;
	localparam logic [KeyW-1:0] K_ENT   = 8'h83;
	localparam logic [KeyW-1:0] K_F1    = 8'h84;
	localparam logic [KeyW-1:0] K_F2    = 8'h85;
	localparam logic [KeyW-1:0] K_F3    = 8'h86;
	localparam logic [KeyW-1:0] K_F4    = 8'h87;
	localparam logic [KeyW-1:0] K_F5    = 8'h88;
	localparam logic [KeyW-1:0] K_F6    = 8'h89;
	localparam logic [KeyW-1:0] K_F7    = 8'h8A;
	localparam logic [KeyW-1:0] K_F8    = 8'h8B;
	localparam logic [KeyW-1:0] K_F9    = 8'h8C;
	localparam logic [KeyW-1:0] K_F10   = 8'h8D;
	localparam logic [KeyW-1:0] K_F11   = 8'h8E;
	localparam logic [KeyW-1:0] K_F12   = 8'h8F;
	localparam logic [KeyW-1:0] K_UP    = 8'h90;
	localparam logic [KeyW-1:0] K_DOWN  = 8'h91;
	localparam logic [KeyW-1:0] K_LEFT  = 8'h92;
	localparam logic [KeyW-1:0] K_RIGHT = 8'h93;
	localparam logic [KeyW-1:0] K_HOME  = 8'h94;
	localparam logic [KeyW-1:0] K_END   = 8'h95;
	localparam logic [KeyW-1:0] K_PGUP  = 8'h96;
	localparam logic [KeyW-1:0] K_PGDN  = 8'h97;
	localparam logic [KeyW-1:0] K_INS   = 8'h98;
	localparam logic [KeyW-1:0] K_DEL   = 8'h99;

	localparam logic [KeyW-1:0] ASCII_A_LO = 8'h61;
	localparam logic [KeyW-1:0] ASCII_Z_LO = 8'h7A;
	localparam logic [KeyW-1:0] CASE_DIFF  = 8'h20;

	typedef struct packed {
		logic            prefix;
		logic [ModW-1:0] mods;
		logic [LedW-1:0] leds;
	} dec_state_t;

	typedef struct packed {
		logic             event_valid;
		logic [KeyW-1:0]  key_code;
		logic [CodeW-1:0] scan_code;
		logic [ModW-1:0]  modifier_bits;
		logic             key_pressed;
		logic             led_send;
		logic [LedW-1:0]  led_value;
	} key_evt_t;

	function automatic logic [KeyW-1:0] plain_key(input logic [CodeW-1:0] sc);
		logic [KeyW-1:0] k;
		case (sc)
			7'h01: k = K_ESC;
			7'h02: k = 8'h31;
			7'h03: k = 8'h32;
			7'h04: k = 8'h33;
			7'h05: k = 8'h34;
			7'h06: k = 8'h35;
			7'h07: k = 8'h36;
			7'h08: k = 8'h37;
			7'h09: k = 8'h38;
			7'h0A: k = 8'h39;
			7'h0B: k = 8'h30;
			7'h0C: k = 8'h2D;
			7'h0D: k = 8'h3D;
			7'h0E: k = K_BS;
			7'h0F: k = K_TAB;
			7'h10: k = 8'h71;
			7'h11: k = 8'h77;
			7'h12: k = 8'h65;
			7'h13: k = 8'h72;
			7'h14: k = 8'h74;
			7'h15: k = 8'h79;
			7'h16: k = 8'h75;
			7'h17: k = 8'h69;
			7'h18: k = 8'h6F;
			7'h19: k = 8'h70;
			7'h1A: k = 8'h5B;
			7'h1B: k = 8'h5D;
			7'h1C: k = K_ENT;
			7'h1E: k = 8'h61;
			7'h1F: k = 8'h73;
			7'h20: k = 8'h64;
			7'h21: k = 8'h66;
			7'h22: k = 8'h67;
			7'h23: k = 8'h68;
			7'h24: k = 8'h6A;
			7'h25: k = 8'h6B;
			7'h26: k = 8'h6C;
			7'h27: k = 8'h3B;
			7'h28: k = 8'h27;
			7'h29: k = 8'h60;
			7'h2B: k = 8'h5C;
			7'h2C: k = 8'h7A;
			7'h2D: k = 8'h78;
			7'h2E: k = 8'h63;
			7'h2F: k = 8'h76;
			7'h30: k = 8'h62;
			7'h31: k = 8'h6E;
			7'h32: k = 8'h6D;
			7'h33: k = 8'h2C;
			7'h34: k = 8'h2E;
			7'h35: k = 8'h2F;
			7'h37: k = 8'h2A;
			7'h39: k = 8'h20;
			7'h3B: k = K_F1;
			7'h3C: k = K_F2;
			7'h3D: k = K_F3;
			7'h3E: k = K_F4;
			7'h3F: k = K_F5;
			7'h40: k = K_F6;
			7'h41: k = K_F7;
			7'h42: k = K_F8;
			7'h43: k = K_F9;
			7'h44: k = K_F10;
			7'h47: k = 8'h37;
			7'h48: k = 8'h38;
			7'h49: k = 8'h39;
			7'h4A: k = 8'h2D;
			7'h4B: k = 8'h34;
			7'h4C: k = 8'h35;
			7'h4D: k = 8'h36;
			7'h4E: k = 8'h2B;
			7'h4F: k = 8'h31;
			7'h50: k = 8'h32;
			7'h51: k = 8'h33;
			7'h52: k = 8'h30;
			7'h53: k = 8'h2E;
			7'h57: k = K_F11;
			7'h58: k = K_F12;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic is_lower(input logic [KeyW-1:0] k);
		return (k >= ASCII_A_LO) && (k <= ASCII_Z_LO);
	endfunction

	function automatic logic [KeyW-1:0] shifted_key(input logic [CodeW-1:0] sc);
		logic [KeyW-1:0] k;
		case (sc)
			7'h02: k = 8'h21;
			7'h03: k = 8'h40;
			7'h04: k = 8'h23;
			7'h05: k = 8'h24;
			7'h06: k = 8'h25;
			7'h07: k = 8'h5E;
			7'h08: k = 8'h26;
			7'h09: k = 8'h2A;
			7'h0A: k = 8'h28;
			7'h0B: k = 8'h29;
			7'h0C: k = 8'h5F;
			7'h0D: k = 8'h2B;
			7'h1A: k = 8'h7B;
			7'h1B: k = 8'h7D;
			7'h27: k = 8'h3A;
			7'h28: k = 8'h22;
			7'h29: k = 8'h7E;
			7'h2B: k = 8'h7C;
			7'h33: k = 8'h3C;
			7'h34: k = 8'h3E;
			7'h35: k = 8'h3F;
			default: begin
				k = plain_key(sc);
				if (is_lower(k))
					k = k - CASE_DIFF;
			end
		endcase
		return k;
	endfunction

	function automatic logic [KeyW-1:0] ext_key(input logic [CodeW-1:0] sc);
		logic [KeyW-1:0] k;
		case (sc)
			7'h48: k = K_UP;
			7'h50: k = K_DOWN;
			7'h4B: k = K_LEFT;
			7'h4D: k = K_RIGHT;
			7'h47: k = K_HOME;
			7'h4F: k = K_END;
			7'h49: k = K_PGUP;
			7'h51: k = K_PGDN;
			7'h52: k = K_INS;
			7'h53: k = K_DEL;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

endpackage

[rtl/core/ps2sc_ifs.sv]
// Valid/ready channel interfaces for scancode bytes and decoded key events.
interface ps2sc_scan_if import ps2sc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ScanW-1:0] scan_byte;

	modport source (output valid, output scan_byte, input ready);
	modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2sc_key_if import ps2sc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             event_valid;
	logic [KeyW-1:0]  key_code;
	logic [CodeW-1:0] scan_code;
	logic [ModW-1:0]  modifier_bits;
	logic             key_pressed;
	logic             led_send;
	logic [LedW-1:0]  led_value;

	modport source (output valid, output event_valid, output key_code, output scan_code,
		output modifier_bits, output key_pressed, output led_send, output led_value,
		input ready);
	modport sink   (input valid, input event_valid, input key_code, input scan_code,
		input modifier_bits, input key_pressed, input led_send, input led_value,
		output ready);
endinterface

[rtl/core/ps2sc_decode.sv]
// Single-pass decode of one scancode byte: modifier update, lock toggles and key lookup.
module ps2sc_decode import ps2sc_pkg::*; (
	input  logic [ScanW-1:0] scan_byte,
	input  logic             event_enable,
	input  dec_state_t       cur,
	output dec_state_t       nxt,
	output key_evt_t         res
);

	logic             released;
	logic [CodeW-1:0] sc;
	logic             hit;
	logic             send;
	logic             lock_hit;
	logic [ModW-1:0]  mods;
	logic [LedW-1:0]  leds_new;
	logic [KeyW-1:0]  key;
	logic [KeyW-1:0]  plain;

	assign released = scan_byte[ScanW-1];
	assign sc       = scan_byte[CodeW-1:0];
	assign plain    = plain_key(sc);

	always_comb begin
		mods     = cur.mods;
		hit      = 1'b0;
		lock_hit = 1'b0;
		if (!cur.prefix) begin
			case (sc)
				SC_LSHIFT: begin mods[M_LSHIFT] = !released; hit = 1'b1; end
				SC_RSHIFT: begin mods[M_RSHIFT] = !released; hit = 1'b1; end
				SC_CTRL:   begin mods[M_LCTRL]  = !released; hit = 1'b1; end
				SC_ALT:    begin mods[M_LALT]   = !released; hit = 1'b1; end
				SC_CAPS: begin
					mods[M_CAPS] = cur.mods[M_CAPS] ^ !released;
					lock_hit = !released;
					hit = 1'b1;
				end
				SC_NUM: begin
					mods[M_NUM] = cur.mods[M_NUM] ^ !released;
					lock_hit = !released;
					hit = 1'b1;
				end
				SC_SCROLL: begin
					mods[M_SCROLL] = cur.mods[M_SCROLL] ^ !released;
					lock_hit = !released;
					hit = 1'b1;
				end
				default: ;
			endcase
		end else begin
			case (sc)
				SC_CTRL: begin mods[M_RCTRL] = !released; hit = 1'b1; end
				SC_ALT:  begin mods[M_RALT]  = !released; hit = 1'b1; end
				default: ;
			endcase
		end
	end

	assign leds_new = {mods[M_CAPS], mods[M_NUM], mods[M_SCROLL]};
	assign send     = lock_hit && (leds_new != cur.leds);

	// Shift wins over caps lock; caps only raises letters
	always_comb begin
		if (cur.prefix)
			key = ext_key(sc);
		else if (mods[M_LSHIFT] || mods[M_RSHIFT])
			key = shifted_key(sc);
		else if (mods[M_CAPS] && is_lower(plain))
			key = plain - CASE_DIFF;
		else
			key = plain;
	end

	always_comb begin
		if (scan_byte == SC_PREFIX) begin
			nxt.prefix        = 1'b1;
			nxt.mods          = cur.mods;
			nxt.leds          = cur.leds;
			res.event_valid   = 1'b0;
			res.key_code      = K_NONE;
			res.scan_code     = '0;
			res.modifier_bits = cur.mods;
			res.key_pressed   = 1'b0;
			res.led_send      = 1'b0;
			res.led_value     = cur.leds;
		end else begin
			nxt.prefix        = 1'b0;
			nxt.mods          = mods;
			nxt.leds          = send ? leds_new : cur.leds;
			res.event_valid   = event_enable && ((key != K_NONE) || hit);
			res.key_code      = key;
			res.scan_code     = sc;
			res.modifier_bits = mods;
			res.key_pressed   = !released;
			res.led_send      = send;
			res.led_value     = send ? leds_new : cur.leds;
		end
	end

endmodule

[rtl/core/ps2_scancode_to_key.sv]
// PS/2 scancode set 1 to key event decoder, top level.
//
// Usage:
//   scan  - sink channel of raw set 1 bytes; 0xE0 arms the extended flag for the
//           next byte, bit 7 of a byte marks a key release.
//   key   - source channel of one key event per byte: key code, scancode,
//           modifier word, make/break, event flag and lock LED update request.
//   cfg_we / cfg_wdata - write of the event enable bit; write it while idle.
// A transferred byte shows its event in the cycle after the transfer. Decode is a
// single combinational pass between the accepted byte and the result register,
// so a byte can be taken every cycle; throughput is one byte per cycle while the
// receiver keeps up.
// When the receiver stalls, the result register holds its event and scan.ready
// drops; it rises again in the cycle the event is taken, so the next byte can
// transfer in that same cycle.
// Reset clears the extended flag, modifiers, lock LEDs, event enable and the
// result valid.
module ps2_scancode_to_key import ps2sc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	ps2sc_scan_if.sink         scan,
	ps2sc_key_if.source        key
);

	logic       event_enable_q;
	dec_state_t state_q;
	dec_state_t state_nxt;
	key_evt_t   res;
	key_evt_t   res_q;
	logic       out_valid_q;
	logic       accept;

	assign scan.ready = !out_valid_q || key.ready;
	assign accept     = scan.valid && scan.ready;

	ps2sc_decode u_decode (
		.scan_byte    (scan.scan_byte),
		.event_enable (event_enable_q),
		.cur          (state_q),
		.nxt          (state_nxt),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_enable_q <= 1'b0;
		end else if (cfg_we) begin
			event_enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (key.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload: load on transfer, hold otherwise
	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res;
	end

	assign key.valid         = out_valid_q;
	assign key.event_valid   = res_q.event_valid;
	assign key.key_code      = res_q.key_code;
	assign key.scan_code     = res_q.scan_code;
	assign key.modifier_bits = res_q.modifier_bits;
	assign key.key_pressed   = res_q.key_pressed;
	assign key.led_send      = res_q.led_send;
	assign key.led_value     = res_q.led_value;

	a_accept_gives_event: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> key.valid)
		else $error("accepted byte did not produce an event");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(key.valid && !key.ready) |-> !scan.ready)
		else $error("input taken while result is stalled");

	a_prefix_arms_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (scan.scan_byte == SC_PREFIX)) |=> state_q.prefix)
		else $error("prefix byte did not arm the extended flag");

	a_leds_track_locks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.leds == {state_q.mods[M_CAPS], state_q.mods[M_NUM], state_q.mods[M_SCROLL]})
		else $error("LED pattern out of step with lock bits");

	a_prefix_event_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (scan.scan_byte == SC_PREFIX)) |=> (!key.event_valid && !key.led_send))
		else $error("prefix byte flagged an event");

endmodule
